/* rtl/core/bhpq_pkg.sv */
// Shared types, codes and compare function for the binary heap priority queue.
`default_nettype none
package bhpq_pkg;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // Heap order register values
   localparam logic ORDER_MAX = 1'b0;
   localparam logic ORDER_MIN = 1'b1;

   // Decoded operation
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Command passed from front to back
   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

   // True when key x must sit above key y under the given order
   function automatic logic ranks_above(input logic order, input logic [31:0] x,
                                        input logic [31:0] y);
      logic [31:0] kx;
      logic [31:0] ky;
      kx = x ^ 32'h8000_0000;
      ky = y ^ 32'h8000_0000;
      if (order == ORDER_MIN) begin
         return kx < ky;
      end
      return kx > ky;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/bhpq_if.sv */
// Request and response channel interfaces of the heap queue.
`default_nettype none
interface bhpq_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] value;
   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bhpq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] removed_value;
   logic signed [31:0] top_value;
   logic [10:0]        entry_count;
   logic [1:0]         status;
   modport source (output valid, output removed_value, output top_value,
                   output entry_count, output status, input ready);
   modport sink   (input valid, input removed_value, input top_value,
                   input entry_count, input status, output ready);
endinterface
`default_nettype wire

/* rtl/core/bhpq_front.sv */
// Front end: accepts request items, decodes them and queues commands.
`default_nettype none
module bhpq_front (
   input  wire logic         clock,
   input  wire logic         reset,
   bhpq_req_if.sink          req_chan,
   output bhpq_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  wire logic         cmd_ready
);
   import bhpq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   cmd_type    decoded;

   // Decode the incoming item
   always_comb begin
      decoded.op    = (req_chan.mode == MODE_REMOVE) ? OP_REMOVE : OP_INSERT;
      decoded.value = req_chan.value;
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push      = req_chan.valid && req_chan.ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = slot_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/bhpq_back.sv */
// Back end: heap memory and the sift sequencer, with the result register.
`default_nettype none
module bhpq_back #(
   parameter int CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         heap_order,
   input  bhpq_pkg::cmd_type cmd,
   input  wire logic         cmd_valid,
   output logic              cmd_ready,
   bhpq_rsp_if.source        rsp_chan
);
   import bhpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_UP_CMP  = 11'b000_0000_0010,
      S_UP_PUT  = 11'b000_0000_0100,
      S_DN_ROOT = 11'b000_0000_1000,
      S_DN_LAST = 11'b000_0001_0000,
      S_DN_STEP = 11'b000_0010_0000,
      S_DN_L    = 11'b000_0100_0000,
      S_DN_R    = 11'b000_1000_0000,
      S_DN_CMP  = 11'b001_0000_0000,
      S_TOP_RD  = 11'b010_0000_0000,
      S_TOP_GET = 11'b100_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [31:0]    cur_ff, cur_in;
   logic [31:0]    child_ff, child_in;
   logic [AW-1:0]  child_pos_ff, child_pos_in;
   logic [31:0]    removed_ff, removed_in;
   logic [1:0]     status_ff, status_in;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_removed_ff, out_removed_in;
   logic [31:0]    out_top_ff, out_top_in;
   logic [CW-1:0]  out_count_ff, out_count_in;
   logic [1:0]     out_status_ff, out_status_in;

   logic [31:0]    heap_mem [CAPACITY];
   logic [31:0]    rd_data_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [31:0]    wr_data;

   logic [AW-1:0]  parent_pos;
   logic [AW-1:0]  parent_next;
   logic [LW-1:0]  left_idx;
   logic [LW-1:0]  right_idx;
   logic [LW-1:0]  count_wide;
   logic [CW+10:0] count_ext;

   // Child and parent index math
   always_comb begin
      parent_pos  = (pos_ff - AW'(1)) >> 1;
      parent_next = (parent_pos - AW'(1)) >> 1;
      left_idx    = {1'b0, pos_ff, 1'b1};
      right_idx   = left_idx + LW'(1);
      count_wide  = LW'(count_ff);
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      child_in       = child_ff;
      child_pos_in   = child_pos_ff;
      removed_in     = removed_ff;
      status_in      = status_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_removed_in = out_removed_ff;
      out_top_in     = out_top_ff;
      out_count_in   = out_count_ff;
      out_status_in  = out_status_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = cur_ff;
      cmd_ready      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready  = 1'b1;
            removed_in = '0;
            status_in  = ST_DONE;
            if (cmd_valid) begin
               if (cmd.op == OP_INSERT) begin
                  if (count_ff >= CAP_COUNT) begin
                     status_in = ST_FULL;
                     state_in  = S_TOP_RD;
                  end else begin
                     cur_in   = cmd.value;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = cmd.value;
                        state_in = S_TOP_RD;
                     end else begin
                        rd_addr  = (count_ff[AW-1:0] - AW'(1)) >> 1;
                        state_in = S_UP_CMP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_TOP_RD;
                  end else begin
                     count_in = count_ff - CW'(1);
                     rd_addr  = '0;
                     state_in = S_DN_ROOT;
                  end
               end
            end
         end
         // Sift up: move the parent down into the hole while the new key beats it
         S_UP_CMP: begin
            if (ranks_above(heap_order, cur_ff, rd_data_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = parent_pos;
               if (parent_pos == '0) begin
                  state_in = S_UP_PUT;
               end else begin
                  rd_addr = parent_next;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_TOP_RD;
            end
         end
         S_UP_PUT: begin
            wr_en    = 1'b1;
            state_in = S_TOP_RD;
         end
         S_DN_ROOT: begin
            removed_in = rd_data_ff;
            rd_addr    = count_ff[AW-1:0];
            state_in   = S_DN_LAST;
         end
         S_DN_LAST: begin
            cur_in   = rd_data_ff;
            pos_in   = '0;
            state_in = S_DN_STEP;
         end
         // Sift down: fetch the children of the hole
         S_DN_STEP: begin
            if (left_idx >= count_wide) begin
               wr_en    = 1'b1;
               state_in = S_TOP_RD;
            end else begin
               rd_addr  = left_idx[AW-1:0];
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            child_in     = rd_data_ff;
            child_pos_in = left_idx[AW-1:0];
            if (right_idx < count_wide) begin
               rd_addr  = right_idx[AW-1:0];
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            if (!ranks_above(heap_order, child_ff, rd_data_ff)) begin
               child_in     = rd_data_ff;
               child_pos_in = right_idx[AW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (ranks_above(heap_order, child_ff, cur_ff)) begin
               wr_data  = child_ff;
               pos_in   = child_pos_ff;
               state_in = S_DN_STEP;
            end else begin
               state_in = S_TOP_RD;
            end
         end
         S_TOP_RD: begin
            rd_addr  = '0;
            state_in = S_TOP_GET;
         end
         // Load the result register once it is free
         S_TOP_GET: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in   = 1'b1;
               out_removed_in = removed_ff;
               out_top_in     = (count_ff != '0) ? rd_data_ff : '0;
               out_count_in   = count_ff;
               out_status_in  = status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      child_ff       <= child_in;
      child_pos_ff   <= child_pos_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      out_removed_ff <= out_removed_in;
      out_top_ff     <= out_top_in;
      out_count_ff   <= out_count_in;
      out_status_ff  <= out_status_in;
   end

   // Heap memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   // Result channel
   assign count_ext              = {11'b0, out_count_ff};
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.removed_value = out_removed_ff;
   assign rsp_chan.top_value     = out_top_ff;
   assign rsp_chan.entry_count   = count_ext[10:0];
   assign rsp_chan.status        = out_status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   a_hole_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN_STEP && count_ff != '0) |-> (CW'(pos_ff) < count_ff))
      else $error("sift-down hole outside stored entries");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP_GET && status_ff != ST_DONE) |-> (count_ff == $past(count_ff)))
      else $error("refused item changed the count");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP_GET && status_ff == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty refusal with entries stored");

endmodule
`default_nettype wire

/* rtl/core/binary_heap_priority_queue_core.sv */
// Top level of the binary heap priority queue.
//
//   channel   direction  handshake       payload
//   req_chan  in         valid / ready   mode, value
//   rsp_chan  out        valid / ready   removed_value, top_value, entry_count, status
//   csr       in         write enable    heap_order (1 bit)
//
// An insert sifts up and a remove sifts down, level by level, each step reading
// the heap memory through its single read port; a refused item or an insert into
// an empty heap skips the sift. One item is worked at a time; a two-entry command
// queue keeps accepting while it runs. Reset empties the heap at once
// (no clearing pass). A stalled result holds in the output register.
`default_nettype none
module binary_heap_priority_queue_core #(
   parameter int CAPACITY = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   bhpq_req_if.sink   req_chan,
   bhpq_rsp_if.source rsp_chan,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data
);
   import bhpq_pkg::*;

   logic    order_ff, order_in;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   // Heap order register
   assign order_in = csr_write_enable ? csr_write_data : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_MAX;
      end else begin
         order_ff <= order_in;
      end
   end

   bhpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   bhpq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .heap_order (order_ff),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
